// ===== sv/exchange_sort_engine_defines.svh =====
// Assertion macros used by the exchange sort engine top level.
`ifndef EXCHANGE_SORT_ENGINE_DEFINES_SVH
`define EXCHANGE_SORT_ENGINE_DEFINES_SVH

`ifndef SYNTHESIS

// Same-cycle implication, checked on every rising clock edge outside reset.
`define ESE_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("exchange_sort_engine: assertion failed");

// Next-cycle implication, checked on every rising clock edge outside reset.
`define ESE_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("exchange_sort_engine: assertion failed");

`else

`define ESE_ASSERT_IMP(label, clk, rst, ante, cons)
`define ESE_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

// ===== sv/esort_pkg.sv =====
// Shared constants and controller/datapath interface types for the sort engine.
package esort_pkg;

  // Width of one stored value.
  localparam int DATA_W = 32;

  // Default storage depth.
  localparam int MAX_ITEMS_DEF = 64;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;       // Store the incoming item, or flag it as dropped.
    logic cur_load;   // Take the read data as the carried value of a pass.
    logic pass_step;  // Compare carried value with read data and write the smaller.
    logic end_write;  // Write the carried value at the end of a pass.
    logic out_load;   // Present the read data as a result.
    logic out_last;   // The result being presented closes the set.
    logic clear_set;  // Reset fill count and overflow flag for the next set.
  } esort_cmd_t;

endpackage

// ===== sv/esort_datapath.sv =====
// Datapath of the sort engine: value memory, carry register, counters and result registers.
module esort_datapath #(
  parameter int MAX_ITEMS = esort_pkg::MAX_ITEMS_DEF,
  parameter int AW = $clog2(MAX_ITEMS),
  parameter int CW = $clog2(MAX_ITEMS + 1)
) (
  input  logic                              clk,
  input  logic                              rst,
  input  esort_pkg::esort_cmd_t             cmd,
  input  logic [AW-1:0]                     raddr,
  input  logic [AW-1:0]                     waddr,
  input  logic signed [esort_pkg::DATA_W-1:0] value_in,
  output logic [CW-1:0]                     fill_count,
  output logic                              result_strobe,
  output logic signed [esort_pkg::DATA_W-1:0] sorted_value,
  output logic                              last_out,
  output logic                              overflow_flag
);

  logic signed [esort_pkg::DATA_W-1:0] mem [MAX_ITEMS];
  logic signed [esort_pkg::DATA_W-1:0] rd_data;
  logic signed [esort_pkg::DATA_W-1:0] cur;
  logic                                overflow_seen;
  logic                                has_room;
  logic                                gt;

  assign has_room = (fill_count < CW'(MAX_ITEMS));
  assign gt       = (cur > rd_data);

  // Value memory: one write port and one registered read port.
  always_ff @(posedge clk) begin
    if (cmd.load && has_room) begin
      mem[fill_count[AW-1:0]] <= value_in;
    end else if (cmd.pass_step) begin
      mem[waddr] <= gt ? rd_data : cur;
    end else if (cmd.end_write) begin
      mem[waddr] <= cur;
    end
    rd_data <= mem[raddr];
  end

  // Carried value of a pass: the larger element travels toward the top.
  always_ff @(posedge clk) begin
    if (cmd.cur_load) begin
      cur <= rd_data;
    end else if (cmd.pass_step && !gt) begin
      cur <= rd_data;
    end
  end

  // Fill count and dropped-item flag for the current set.
  always_ff @(posedge clk) begin
    if (rst) begin
      fill_count    <= '0;
      overflow_seen <= 1'b0;
    end else if (cmd.clear_set) begin
      fill_count    <= '0;
      overflow_seen <= 1'b0;
    end else if (cmd.load) begin
      if (has_room) begin
        fill_count <= fill_count + CW'(1);
      end else begin
        overflow_seen <= 1'b1;
      end
    end
  end

  // Result strobe is cleared by reset; the payload needs no reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_strobe <= 1'b0;
    end else begin
      result_strobe <= cmd.out_load;
    end
  end

  // Result payload registers.
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      sorted_value  <= rd_data;
      last_out      <= cmd.out_last;
      overflow_flag <= overflow_seen;
    end
  end

endmodule

// ===== sv/esort_ctrl.sv =====
// Controller of the sort engine: load, sort passes and result emission sequencing.
module esort_ctrl #(
  parameter int MAX_ITEMS = esort_pkg::MAX_ITEMS_DEF,
  parameter int AW = $clog2(MAX_ITEMS),
  parameter int CW = $clog2(MAX_ITEMS + 1)
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  input  logic                     last_in,
  input  logic [CW-1:0]            fill_count,
  output esort_pkg::esort_cmd_t    cmd,
  output logic [AW-1:0]            raddr,
  output logic [AW-1:0]            waddr,
  output logic                     busy
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_CHECK = 3'd1;
  localparam logic [2:0] S_FIRST = 3'd2;
  localparam logic [2:0] S_PASS  = 3'd3;
  localparam logic [2:0] S_END   = 3'd4;
  localparam logic [2:0] S_EMIT  = 3'd5;

  logic [2:0]    state;
  logic [2:0]    state_next;
  logic [AW-1:0] idx;
  logic [AW-1:0] idx_next;
  logic [AW-1:0] top;
  logic [AW-1:0] top_next;
  logic [CW-1:0] cnt_m1;
  logic          is_last;

  assign busy    = (state != S_IDLE);
  assign cnt_m1  = fill_count - CW'(1);
  assign is_last = (idx == cnt_m1[AW-1:0]);

  // State, element index and pass limit registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      idx   <= '0;
      top   <= '0;
    end else begin
      state <= state_next;
      idx   <= idx_next;
      top   <= top_next;
    end
  end

  // Next-state and command decode. Each pass carries the largest value up to top.
  always_comb begin
    state_next = state;
    idx_next   = idx;
    top_next   = top;
    cmd        = '0;
    raddr      = '0;
    waddr      = '0;
    unique case (state)
      S_IDLE: begin
        cmd.load = start;
        if (start && last_in) begin
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        idx_next = '0;
        if (fill_count >= CW'(2)) begin
          top_next   = cnt_m1[AW-1:0];
          state_next = S_FIRST;
        end else begin
          state_next = S_EMIT;
        end
      end
      S_FIRST: begin
        cmd.cur_load = 1'b1;
        raddr        = AW'(1);
        idx_next     = AW'(1);
        state_next   = S_PASS;
      end
      S_PASS: begin
        cmd.pass_step = 1'b1;
        waddr         = idx - AW'(1);
        if (idx == top) begin
          state_next = S_END;
        end else begin
          raddr    = idx + AW'(1);
          idx_next = idx + AW'(1);
        end
      end
      S_END: begin
        cmd.end_write = 1'b1;
        waddr         = top;
        idx_next      = '0;
        top_next      = top - AW'(1);
        state_next    = (top == AW'(1)) ? S_EMIT : S_FIRST;
      end
      S_EMIT: begin
        cmd.out_load = 1'b1;
        cmd.out_last = is_last;
        if (is_last) begin
          cmd.clear_set = 1'b1;
          state_next    = S_IDLE;
        end else begin
          raddr    = idx + AW'(1);
          idx_next = idx + AW'(1);
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

// ===== sv/exchange_sort_engine.sv =====
// Exchange sort engine: loads a marked set of signed values, sorts ascending, emits them.
// Non-final items are taken one per cycle with busy low. After the final item, busy is high
// through one check state, then n-1 shrinking compare-exchange passes over the value memory
// for n stored values (none for fewer than two), then one result per cycle. Results pass
// through the read data register and then the result registers after their memory read.
// Synchronous reset clears the controller, fill count, internal overflow flag and result strobe.
`include "exchange_sort_engine_defines.svh"

module exchange_sort_engine #(
  parameter int MAX_ITEMS = esort_pkg::MAX_ITEMS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  output logic                                busy,
  input  logic signed [esort_pkg::DATA_W-1:0] value_in,
  input  logic                                last_in,
  output logic                                result_strobe,
  output logic signed [esort_pkg::DATA_W-1:0] sorted_value,
  output logic                                last_out,
  output logic                                overflow_flag
);

  localparam int AW = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
  localparam int CW = $clog2(MAX_ITEMS + 1);

  esort_pkg::esort_cmd_t    cmd;
  logic [AW-1:0]            raddr;
  logic [AW-1:0]            waddr;
  logic [CW-1:0]            fill_count;

  // Sequencer for load, sort passes and emission.
  esort_ctrl #(
    .MAX_ITEMS (MAX_ITEMS),
    .AW        (AW),
    .CW        (CW)
  ) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .last_in    (last_in),
    .fill_count (fill_count),
    .cmd        (cmd),
    .raddr      (raddr),
    .waddr      (waddr),
    .busy       (busy)
  );

  // Storage, compare-exchange logic and result registers.
  esort_datapath #(
    .MAX_ITEMS (MAX_ITEMS),
    .AW        (AW),
    .CW        (CW)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .raddr         (raddr),
    .waddr         (waddr),
    .value_in      (value_in),
    .fill_count    (fill_count),
    .result_strobe (result_strobe),
    .sorted_value  (sorted_value),
    .last_out      (last_out),
    .overflow_flag (overflow_flag)
  );

  // The final result of a set is never followed directly by another result.
  `ESE_ASSERT_NEXT(a_last_ends_set, clk, rst, result_strobe && last_out, !result_strobe)

  // Accepting the closing item of a set makes the engine busy.
  `ESE_ASSERT_NEXT(a_last_sets_busy, clk, rst, start && !busy && last_in, busy)

  // Every result is produced by work that began while the engine was busy.
  `ESE_ASSERT_IMP(a_result_from_busy, clk, rst, result_strobe, $past(busy))

  // The fill count never exceeds the storage depth.
  `ESE_ASSERT_IMP(a_fill_bounded, clk, rst, 1'b1, fill_count <= CW'(MAX_ITEMS))

endmodule

// ===== tb/exchange_sort_engine_test.sv =====
// Self-checking testbench for the exchange sort engine: directed and random sets of values.
module exchange_sort_engine_test;

  localparam int DATA_W   = esort_pkg::DATA_W;
  localparam int CAPACITY = esort_pkg::MAX_ITEMS_DEF;
  localparam int DIRECTED_ROWS = 25;
  localparam int RANDOM_ITEMS  = 235;
  localparam int QUIET_LIMIT   = 20000;
  localparam int DRAIN_CYCLES  = 3 * CAPACITY;

  localparam logic [DATA_W-1:0] MOST_NEGATIVE = 32'h8000_0000;
  localparam logic [DATA_W-1:0] MOST_POSITIVE = 32'h7fff_ffff;

  // One expected result of a sorted set.
  typedef struct packed {
    logic [DATA_W-1:0] value;
    logic              last;
    logic              ovf;
  } sorted_result_t;

  // One row of the directed stimulus; typed rows carry their own single expected result.
  typedef struct packed {
    logic [DATA_W-1:0] value;
    logic              last;
    logic              typed;
    logic [DATA_W-1:0] want_value;
    logic              want_last;
    logic              want_ovf;
  } stim_row_t;

  logic                     clk;
  logic                     rst = 1'b1;
  logic                     start = 1'b0;
  logic                     busy;
  logic signed [DATA_W-1:0] value_in = '0;
  logic                     last_in = 1'b0;
  logic                     result_strobe;
  logic signed [DATA_W-1:0] sorted_value;
  logic                     last_out;
  logic                     overflow_flag;

  // Predictor state: values of the open set, their count, and the dropped-value flag.
  logic [DATA_W-1:0] held_values [CAPACITY];
  int                held_count = 0;
  bit                dropped_any = 1'b0;

  sorted_result_t pending_results [$];
  sorted_result_t due;
  int             mismatches = 0;
  int             quiet_cycles = 0;
  int             set_no = 0;

  // Sender idle percentage per phase: none, heavy, none, light.
  int idle_pct_by_phase [4] = '{0, 51, 0, 6};

  stim_row_t directed_rows [DIRECTED_ROWS] = '{
    // Single-value sets at the extremes and around zero: the value comes straight back.
    '{MOST_NEGATIVE, 1'b1, 1'b1, MOST_NEGATIVE, 1'b1, 1'b0},
    '{MOST_POSITIVE, 1'b1, 1'b1, MOST_POSITIVE, 1'b1, 1'b0},
    '{32'h0000_0000, 1'b1, 1'b1, 32'h0000_0000, 1'b1, 1'b0},
    '{32'hffff_ffff, 1'b1, 1'b1, 32'hffff_ffff, 1'b1, 1'b0},
    '{32'h0000_0001, 1'b1, 1'b1, 32'h0000_0001, 1'b1, 1'b0},
    // Extremes in reverse order.
    '{MOST_POSITIVE, 1'b0, 1'b0, '0, 1'b0, 1'b0},
    '{MOST_NEGATIVE, 1'b0, 1'b0, '0, 1'b0, 1'b0},
    '{32'h0000_0000, 1'b0, 1'b0, '0, 1'b0, 1'b0},
    '{32'hffff_ffff, 1'b1, 1'b0, '0, 1'b0, 1'b0},
    // Strictly descending set, the most swaps for its size.
    '{32'd5, 1'b0, 1'b0, '0, 1'b0, 1'b0},
    '{32'd4, 1'b0, 1'b0, '0, 1'b0, 1'b0},
    '{32'd3, 1'b0, 1'b0, '0, 1'b0, 1'b0},
    '{32'd2, 1'b0, 1'b0, '0, 1'b0, 1'b0},
    '{32'd1, 1'b1, 1'b0, '0, 1'b0, 1'b0},
    // Equal values interleaved.
    '{32'd7, 1'b0, 1'b0, '0, 1'b0, 1'b0},
    '{-32'sd7, 1'b0, 1'b0, '0, 1'b0, 1'b0},
    '{32'd7, 1'b0, 1'b0, '0, 1'b0, 1'b0},
    '{-32'sd7, 1'b0, 1'b0, '0, 1'b0, 1'b0},
    '{32'd7, 1'b1, 1'b0, '0, 1'b0, 1'b0},
    // Values next to the sign boundary and the extremes.
    '{32'h7fff_fffe, 1'b0, 1'b0, '0, 1'b0, 1'b0},
    '{32'h8000_0001, 1'b0, 1'b0, '0, 1'b0, 1'b0},
    '{32'hffff_fffe, 1'b0, 1'b0, '0, 1'b0, 1'b0},
    '{32'h0000_0001, 1'b0, 1'b0, '0, 1'b0, 1'b0},
    '{32'hffff_ffff, 1'b0, 1'b0, '0, 1'b0, 1'b0},
    '{32'h0000_0000, 1'b1, 1'b0, '0, 1'b0, 1'b0}
  };

  exchange_sort_engine #(
    .MAX_ITEMS(CAPACITY)
  ) u_top (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .value_in(value_in),
    .last_in(last_in),
    .result_strobe(result_strobe),
    .sorted_value(sorted_value),
    .last_out(last_out),
    .overflow_flag(overflow_flag)
  );

  // Clock with a period of 20.
  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // Take one accepted value into the open set; on the final value, queue the sorted set.
  task automatic absorb_value(input logic [DATA_W-1:0] v, input logic l, input bit queue_it);
    logic [DATA_W-1:0] work [CAPACITY];
    logic [DATA_W-1:0] key;
    sorted_result_t    res;
    int                i;
    int                j;
    if (held_count < CAPACITY) begin
      held_values[held_count] = v;
      held_count++;
    end else begin
      dropped_any = 1'b1;
    end
    if (l) begin
      // Insertion sort in signed order; the ascending order of a multiset is unique.
      for (i = 0; i < held_count; i++) begin
        key = held_values[i];
        j = i - 1;
        while (j >= 0 && $signed(work[j]) > $signed(key)) begin
          work[j + 1] = work[j];
          j--;
        end
        work[j + 1] = key;
      end
      if (queue_it) begin
        for (i = 0; i < held_count; i++) begin
          res.value = work[i];
          res.last  = (i == held_count - 1);
          res.ovf   = dropped_any;
          pending_results.push_back(res);
        end
      end
      held_count  = 0;
      dropped_any = 1'b0;
    end
  endtask

  // Present one item after a random idle gap and hold it until the block takes it.
  task automatic send_item(input logic [DATA_W-1:0] v, input logic l, input int idle_pct);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start    <= 1'b1;
    value_in <= v;
    last_in  <= l;
    do @(posedge clk); while (busy);
  endtask

  // Random value: extremes, a narrow band for duplicates, or any 32-bit pattern.
  function automatic logic [DATA_W-1:0] pick_value();
    logic [DATA_W-1:0] v;
    case ($urandom_range(9))
      0: v = MOST_NEGATIVE;
      1: v = MOST_POSITIVE;
      2, 3: v = $signed($urandom_range(16)) - 8;
      default: v = $urandom;
    endcase
    return v;
  endfunction

  // Result checker: every strobe is compared with the oldest expectation.
  always @(posedge clk) begin
    if (!rst && result_strobe) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result: expected none, actual value %0d last %0b ovf %0b",
                 $time, sorted_value, last_out, overflow_flag);
        mismatches++;
      end else begin
        due = pending_results.pop_front();
        if (sorted_value !== $signed(due.value)) begin
          $display("%0t: sorted_value expected %0d actual %0d",
                   $time, $signed(due.value), sorted_value);
          mismatches++;
        end
        if (last_out !== due.last) begin
          $display("%0t: last_out expected %0b actual %0b", $time, due.last, last_out);
          mismatches++;
        end
        if (overflow_flag !== due.ovf) begin
          $display("%0t: overflow_flag expected %0b actual %0b", $time, due.ovf, overflow_flag);
          mismatches++;
        end
      end
    end
  end

  // Count cycles in which neither an item nor a result is accepted.
  always @(posedge clk) begin
    if (rst || (start && !busy) || result_strobe) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Watchdog: a hung block ends the run.
  initial begin
    while (quiet_cycles < QUIET_LIMIT) @(posedge clk);
    $display("%0t: no progress for %0d cycles", $time, QUIET_LIMIT);
    $display("** exchange_sort_engine: FAILED **");
    $finish;
  end

  // Stimulus.
  initial begin
    int                row;
    int                items_sent;
    int                rand_set;
    int                set_size;
    int                k;
    int                idle_pct;
    sorted_result_t    typed_res;
    logic [DATA_W-1:0] v;

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Directed table.
    for (row = 0; row < DIRECTED_ROWS; row++) begin
      idle_pct = idle_pct_by_phase[(set_no / 3) % 4];
      send_item(directed_rows[row].value, directed_rows[row].last, idle_pct);
      absorb_value(directed_rows[row].value, directed_rows[row].last,
                   !directed_rows[row].typed);
      if (directed_rows[row].typed) begin
        typed_res.value = directed_rows[row].want_value;
        typed_res.last  = directed_rows[row].want_last;
        typed_res.ovf   = directed_rows[row].want_ovf;
        pending_results.push_back(typed_res);
      end
      if (directed_rows[row].last) set_no++;
    end

    // Random sets: mostly small, with a full store, a dropped final value and a long overrun.
    items_sent = 0;
    rand_set = 0;
    while (items_sent < RANDOM_ITEMS || rand_set <= 7) begin
      case (rand_set)
        1: set_size = CAPACITY;
        4: set_size = CAPACITY + 1;
        7: set_size = CAPACITY + 6;
        default: set_size = ($urandom_range(9) == 0) ? $urandom_range(9, 24)
                                                      : $urandom_range(1, 8);
      endcase
      idle_pct = idle_pct_by_phase[(set_no / 3) % 4];
      for (k = 0; k < set_size; k++) begin
        v = pick_value();
        send_item(v, k == set_size - 1, idle_pct);
        absorb_value(v, k == set_size - 1, 1'b1);
      end
      items_sent += set_size;
      rand_set++;
      set_no++;
    end
    start <= 1'b0;

    // Wait for the last results, then watch for stray ones.
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatches == 0) begin
      $display("** exchange_sort_engine: PASSED **");
    end else begin
      $display("** exchange_sort_engine: FAILED **");
    end
    $finish;
  end

endmodule
